// File: sv/sdst_pkg.sv
package sdst_pkg;

  // Window length bound and the top position index the counter can reach
  localparam int MAX_POSITIONS = 16384;
  localparam int PROB_W        = 16;
  localparam int POS_W         = 14;
  localparam int REL_W         = 15;
  localparam int NUM_TRACK     = 4;

  localparam logic [PROB_W-1:0] PROB_ONE = 16'h8000;
  localparam logic [POS_W-1:0]  POS_TOP  = ((MAX_POSITIONS - 1) > 16383) ?
                                           {POS_W{1'b1}} : POS_W'(MAX_POSITIONS - 1);
  localparam logic [POS_W-1:0]  OFFSET_RESET = 14'd50;

  // Tracker slots
  localparam int TRK_AG = 0;  // acceptor gain
  localparam int TRK_AL = 1;  // acceptor loss
  localparam int TRK_DG = 2;  // donor gain
  localparam int TRK_DL = 3;  // donor loss

  typedef logic [PROB_W-1:0] prob_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [REL_W-1:0]  rel_t;

  // Registered input word, probabilities already clamped to one
  typedef struct packed {
    prob_t ref_acceptor;
    prob_t ref_donor;
    prob_t alt_acceptor;
    prob_t alt_donor;
    logic  last_position;
  } item_t;

  // One result word
  typedef struct packed {
    prob_t delta_dl;
    prob_t delta_dg;
    prob_t delta_al;
    prob_t delta_ag;
    rel_t  pos_dl;
    rel_t  pos_dg;
    rel_t  pos_al;
    rel_t  pos_ag;
  } result_t;

  // Clamp a probability to one
  function automatic prob_t sat_prob(input prob_t v);
    sat_prob = (v > PROB_ONE) ? PROB_ONE : v;
  endfunction

endpackage

// File: sv/splice_delta_score_tracker.sv
// Splice delta score tracker.
// in_*  : one word per sequence position with the four probabilities (Q1.15,
//         values above one are clamped); in_tlast marks the final position.
// out_* : one word per window, sent after the last position: the four
//         maxima (acceptor gain/loss, donor gain/loss) and their positions
//         minus the center offset, as 15-bit two's complement.
// cfg_* : cfg_wr_en writes the 14-bit center offset (reset value 50); write
//         it only while no window is in flight.
// A last word passes the input register, then the compare/update writes its
//   result into the result register, or the skid word if that stays full.
// Throughput: one word per cycle while in_tready is high, set by the
//   compare/update of the four maxima.
// The result side has a result register plus one skid word, so input words
//   keep flowing while a result waits; in_tready drops while the skid word is
//   held, or while a last word in the input register meets a full result
//   register and out_tready is low.
// Reset clears the maxima, the position counter and both result slots, and
//   restores the offset.
module splice_delta_score_tracker (
  input  logic          clk,
  input  logic          rst_n,
  // ref_acceptor[15:0], ref_donor[31:16], alt_acceptor[47:32], alt_donor[63:48]
  input  logic [63:0]   in_tdata,
  input  logic          in_tlast,
  input  logic          in_tvalid,
  output logic          in_tready,
  // acceptor_gain[15:0], acceptor_loss[31:16], donor_gain[47:32],
  // donor_loss[63:48], acceptor_gain_pos[78:64], acceptor_loss_pos[93:79],
  // donor_gain_pos[108:94], donor_loss_pos[123:109], zero[127:124]
  output logic [127:0]  out_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  logic          cfg_wr_en,
  input  sdst_pkg::pos_t cfg_wr_data
);
  import sdst_pkg::*;

  pos_t    offset_r;
  item_t   stage_r;
  item_t   stage_nxt;
  logic    stage_vld_r;
  logic    in_acc;
  logic    res_push;
  result_t res;
  result_t out_r;
  result_t out_nxt;
  result_t skid_r;
  result_t skid_nxt;
  logic    out_vld_r;
  logic    out_vld_nxt;
  logic    skid_vld_r;
  logic    skid_vld_nxt;
  logic    out_pop;

  // Offset register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
    end else if (cfg_wr_en) begin
      offset_r <= cfg_wr_data;
    end
  end

  // Hold off input while every result slot is spoken for
  assign in_tready = ~skid_vld_r &
                     ~(stage_vld_r & stage_r.last_position & out_vld_r & ~out_tready);
  assign in_acc    = in_tvalid & in_tready;

  // Input register, probabilities clamped on the way in
  always_comb begin
    stage_nxt.ref_acceptor  = sat_prob(in_tdata[15:0]);
    stage_nxt.ref_donor     = sat_prob(in_tdata[31:16]);
    stage_nxt.alt_acceptor  = sat_prob(in_tdata[47:32]);
    stage_nxt.alt_donor     = sat_prob(in_tdata[63:48]);
    stage_nxt.last_position = in_tlast;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else begin
      stage_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stage_r <= stage_nxt;
    end
  end

  sdst_tracker u_tracker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (stage_vld_r),
    .item          (stage_r),
    .center_offset (offset_r),
    .res_push      (res_push),
    .res           (res)
  );

  // Result register plus skid word
  assign out_pop = out_vld_r & out_tready;

  always_comb begin
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (out_pop) begin
      out_nxt      = skid_r;
      out_vld_nxt  = skid_vld_r;
      skid_vld_nxt = 1'b0;
    end
    if (res_push) begin
      if (!out_vld_nxt) begin
        out_nxt     = res;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = res;
        skid_vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000,
                       out_r.pos_dl, out_r.pos_dg, out_r.pos_al, out_r.pos_ag,
                       out_r.delta_dl, out_r.delta_dg, out_r.delta_al, out_r.delta_ag};

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid word held with empty result register");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push & skid_vld_r) |-> out_pop)
    else $error("result pushed with both slots full");

  a_last_not_with_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_vld_r & stage_r.last_position) |-> !skid_vld_r)
    else $error("last word in flight while skid word held");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> out_tvalid)
    else $error("result pushed but not presented");

endmodule

// File: sv/sdst_tracker.sv
module sdst_tracker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  sdst_pkg::item_t   item,
  input  sdst_pkg::pos_t    center_offset,
  output logic              res_push,
  output sdst_pkg::result_t res
);
  import sdst_pkg::*;

  prob_t              best_delta_r [NUM_TRACK];
  prob_t              best_delta_nxt [NUM_TRACK];
  pos_t               best_pos_r [NUM_TRACK];
  pos_t               best_pos_nxt [NUM_TRACK];
  pos_t               pos_cnt_r;
  pos_t               pos_cnt_nxt;
  logic signed [PROB_W:0] diff [NUM_TRACK];
  prob_t              upd_delta [NUM_TRACK];
  pos_t               upd_pos [NUM_TRACK];

  // Signed differences, gain and loss for each site type
  always_comb begin
    diff[TRK_AG] = $signed({1'b0, item.alt_acceptor}) - $signed({1'b0, item.ref_acceptor});
    diff[TRK_AL] = $signed({1'b0, item.ref_acceptor}) - $signed({1'b0, item.alt_acceptor});
    diff[TRK_DG] = $signed({1'b0, item.alt_donor}) - $signed({1'b0, item.ref_donor});
    diff[TRK_DL] = $signed({1'b0, item.ref_donor}) - $signed({1'b0, item.alt_donor});
  end

  // Running maxima: only a strictly larger difference replaces
  always_comb begin
    for (int k = 0; k < NUM_TRACK; k++) begin
      if (diff[k] > $signed({1'b0, best_delta_r[k]})) begin
        upd_delta[k] = diff[k][PROB_W-1:0];
        upd_pos[k]   = pos_cnt_r;
      end else begin
        upd_delta[k] = best_delta_r[k];
        upd_pos[k]   = best_pos_r[k];
      end
    end
  end

  // Next state: advance on each word, clear after the last word of a window
  always_comb begin
    pos_cnt_nxt = pos_cnt_r;
    for (int k = 0; k < NUM_TRACK; k++) begin
      best_delta_nxt[k] = best_delta_r[k];
      best_pos_nxt[k]   = best_pos_r[k];
    end
    if (item_valid) begin
      if (item.last_position) begin
        pos_cnt_nxt = '0;
        for (int k = 0; k < NUM_TRACK; k++) begin
          best_delta_nxt[k] = '0;
          best_pos_nxt[k]   = '0;
        end
      end else begin
        pos_cnt_nxt = (pos_cnt_r < POS_TOP) ? pos_cnt_r + 1'b1 : pos_cnt_r;
        for (int k = 0; k < NUM_TRACK; k++) begin
          best_delta_nxt[k] = upd_delta[k];
          best_pos_nxt[k]   = upd_pos[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_cnt_r <= '0;
      for (int k = 0; k < NUM_TRACK; k++) begin
        best_delta_r[k] <= '0;
        best_pos_r[k]   <= '0;
      end
    end else begin
      pos_cnt_r <= pos_cnt_nxt;
      for (int k = 0; k < NUM_TRACK; k++) begin
        best_delta_r[k] <= best_delta_nxt[k];
        best_pos_r[k]   <= best_pos_nxt[k];
      end
    end
  end

  // Result word, positions relative to the variant (wraps mod 2^15)
  assign res_push     = item_valid & item.last_position;
  assign res.delta_ag = upd_delta[TRK_AG];
  assign res.delta_al = upd_delta[TRK_AL];
  assign res.delta_dg = upd_delta[TRK_DG];
  assign res.delta_dl = upd_delta[TRK_DL];
  assign res.pos_ag   = {1'b0, upd_pos[TRK_AG]} - {1'b0, center_offset};
  assign res.pos_al   = {1'b0, upd_pos[TRK_AL]} - {1'b0, center_offset};
  assign res.pos_dg   = {1'b0, upd_pos[TRK_DG]} - {1'b0, center_offset};
  assign res.pos_dl   = {1'b0, upd_pos[TRK_DL]} - {1'b0, center_offset};

endmodule
